@@ rtl/point_in_triangle_3d_top_macros.svh @@
// Assertion macros for the point-in-triangle block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POINT_IN_TRIANGLE_3D_TOP_MACROS_SVH
`define POINT_IN_TRIANGLE_3D_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PIT3_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PIT3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PIT3_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PIT3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/pit3_pkg.sv @@
// Shared constants and types for the point-in-triangle block.
// No dependencies; used by every module under rtl/.
package pit3_pkg;

   localparam int COORD_BITS_DEFAULT = 20;
   localparam int REQ_FIELDS = 12;
   localparam int AXES = 3;

   localparam int TOL_BITS = 42;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 1;

   localparam int RSP_DATA_BITS = 8;

   // packed so that triangle_valid sits in bit 0
   typedef struct packed {
      logic point_inside;
      logic triangle_valid;
   } verdict_type;

endpackage

@@ rtl/pit3_cross.sv @@
// Stages 1 and 2: edge and offset vectors, then the three cross products.
// Depends on pit3_pkg.
module pit3_cross #(
   parameter int COORD_BITS = pit3_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] point    [pit3_pkg::AXES],
   input  logic signed [COORD_BITS-1:0] vertex_a [pit3_pkg::AXES],
   input  logic signed [COORD_BITS-1:0] vertex_b [pit3_pkg::AXES],
   input  logic signed [COORD_BITS-1:0] vertex_c [pit3_pkg::AXES],
   output logic                         out_valid,
   output logic signed [2*COORD_BITS+2:0] normal [pit3_pkg::AXES],
   output logic signed [2*COORD_BITS+2:0] cross_b [pit3_pkg::AXES],
   output logic signed [2*COORD_BITS+2:0] cross_c [pit3_pkg::AXES]
);
   localparam int DW = COORD_BITS + 1;
   localparam int XW = 2 * DW + 1;

   logic signed [DW-1:0] e1_ff [pit3_pkg::AXES], e1_in [pit3_pkg::AXES];
   logic signed [DW-1:0] e2_ff [pit3_pkg::AXES], e2_in [pit3_pkg::AXES];
   logic signed [DW-1:0] d_ff  [pit3_pkg::AXES], d_in  [pit3_pkg::AXES];
   logic s1_valid_ff;

   logic signed [XW-1:0] n_ff  [pit3_pkg::AXES], n_in  [pit3_pkg::AXES];
   logic signed [XW-1:0] tb_ff [pit3_pkg::AXES], tb_in [pit3_pkg::AXES];
   logic signed [XW-1:0] tc_ff [pit3_pkg::AXES], tc_in [pit3_pkg::AXES];
   logic s2_valid_ff;

   always_comb begin
      for (int i = 0; i < pit3_pkg::AXES; i++) begin
         e1_in[i] = DW'(vertex_b[i]) - DW'(vertex_a[i]);
         e2_in[i] = DW'(vertex_c[i]) - DW'(vertex_a[i]);
         d_in[i]  = DW'(point[i])    - DW'(vertex_a[i]);
      end
   end

   // n = e1 x e2, tb = d x e2, tc = e1 x d
   for (genvar i = 0; i < pit3_pkg::AXES; i++) begin : g_axis
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      logic signed [2*DW-1:0] n_p, n_q, tb_p, tb_q, tc_p, tc_q;

      assign n_p  = e1_ff[J] * e2_ff[K];
      assign n_q  = e1_ff[K] * e2_ff[J];
      assign tb_p = d_ff[J]  * e2_ff[K];
      assign tb_q = d_ff[K]  * e2_ff[J];
      assign tc_p = e1_ff[J] * d_ff[K];
      assign tc_q = e1_ff[K] * d_ff[J];

      assign n_in[i]  = XW'(n_p)  - XW'(n_q);
      assign tb_in[i] = XW'(tb_p) - XW'(tb_q);
      assign tc_in[i] = XW'(tc_p) - XW'(tc_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         d_ff  <= d_in;
         n_ff  <= n_in;
         tb_ff <= tb_in;
         tc_ff <= tc_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign normal    = n_ff;
   assign cross_b   = tb_ff;
   assign cross_c   = tc_ff;

endmodule

@@ rtl/pit3_dot.sv @@
// Stages 3 to 5: split 3x3 wide products into partial products, combine them,
// and sum into |n|^2, sB and sC. Depends on pit3_pkg.
module pit3_dot #(
   parameter int COORD_BITS = pit3_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [2*COORD_BITS+2:0] normal  [pit3_pkg::AXES],
   input  logic signed [2*COORD_BITS+2:0] cross_b [pit3_pkg::AXES],
   input  logic signed [2*COORD_BITS+2:0] cross_c [pit3_pkg::AXES],
   output logic                           out_valid,
   output logic signed [4*COORD_BITS+7:0] norm_sq,
   output logic signed [4*COORD_BITS+7:0] weight_b,
   output logic signed [4*COORD_BITS+7:0] weight_c
);
   localparam int DW = COORD_BITS + 1;
   localparam int XW = 2 * DW + 1;
   localparam int LO = XW / 2;
   localparam int HI = XW - LO;
   localparam int PW = 2 * XW;
   localparam int SW = PW + 2;
   localparam int NP = 3 * pit3_pkg::AXES;

   logic signed [2*HI-1:0]   hh_ff [NP], hh_in [NP];
   logic signed [HI+LO:0]    hl_ff [NP], hl_in [NP];
   logic signed [HI+LO:0]    lh_ff [NP], lh_in [NP];
   logic signed [2*LO+1:0]   ll_ff [NP], ll_in [NP];
   logic signed [PW-1:0]     prod_ff [NP], prod_in [NP];
   logic signed [SW-1:0]     nn_ff, sb_ff, sc_ff;
   logic s3_valid_ff, s4_valid_ff, s5_valid_ff;

   // product q: group 0 is n.n, group 1 is n.tb, group 2 is n.tc
   for (genvar q = 0; q < NP; q++) begin : g_prod
      localparam int AX  = q % 3;
      localparam int GRP = q / 3;
      logic signed [XW-1:0] op_a, op_b;
      logic signed [HI-1:0] a_hi, b_hi;
      logic signed [LO:0]   a_lo, b_lo;

      assign op_a = normal[AX];
      assign op_b = (GRP == 0) ? normal[AX] : ((GRP == 1) ? cross_b[AX] : cross_c[AX]);
      assign a_hi = $signed(op_a[XW-1:LO]);
      assign b_hi = $signed(op_b[XW-1:LO]);
      assign a_lo = $signed({1'b0, op_a[LO-1:0]});
      assign b_lo = $signed({1'b0, op_b[LO-1:0]});

      assign hh_in[q] = a_hi * b_hi;
      assign hl_in[q] = a_hi * b_lo;
      assign lh_in[q] = a_lo * b_hi;
      assign ll_in[q] = a_lo * b_lo;

      // exact product fits PW bits, so wraparound of the shifted terms is harmless
      assign prod_in[q] = (PW'(hh_ff[q]) <<< (2 * LO)) + (PW'(hl_ff[q]) <<< LO)
                        + (PW'(lh_ff[q]) <<< LO) + PW'(ll_ff[q]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         lh_ff   <= lh_in;
         ll_ff   <= ll_in;
         prod_ff <= prod_in;
         nn_ff   <= SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);
         sb_ff   <= SW'(prod_ff[3]) + SW'(prod_ff[4]) + SW'(prod_ff[5]);
         sc_ff   <= SW'(prod_ff[6]) + SW'(prod_ff[7]) + SW'(prod_ff[8]);
      end
   end

   assign out_valid = s5_valid_ff;
   assign norm_sq   = nn_ff;
   assign weight_b  = sb_ff;
   assign weight_c  = sc_ff;

endmodule

@@ rtl/pit3_tol_sq.sv @@
// Squares the tolerance register over two register stages, free running.
// Depends on pit3_pkg.
module pit3_tol_sq (
   input  logic                              clock,
   input  logic [pit3_pkg::TOL_BITS-1:0]     tolerance,
   output logic [2*pit3_pkg::TOL_BITS-1:0]   tol_sq
);
   localparam int TW = pit3_pkg::TOL_BITS;
   localparam int LO = TW / 2;
   localparam int HI = TW - LO;
   localparam int QW = 2 * TW;

   logic [HI-1:0]    t_hi;
   logic [LO-1:0]    t_lo;
   logic [2*HI-1:0]  hh_ff, hh_in;
   logic [HI+LO-1:0] hl_ff, hl_in;
   logic [2*LO-1:0]  ll_ff, ll_in;
   logic [QW-1:0]    sq_ff, sq_in;

   assign t_hi  = tolerance[TW-1:LO];
   assign t_lo  = tolerance[LO-1:0];
   assign hh_in = t_hi * t_hi;
   assign hl_in = t_hi * t_lo;
   assign ll_in = t_lo * t_lo;

   // cross term appears twice in a square
   assign sq_in = (QW'(hh_ff) << (2 * LO)) + (QW'(hl_ff) << (LO + 1)) + QW'(ll_ff);

   always_ff @(posedge clock) begin
      hh_ff <= hh_in;
      hl_ff <= hl_in;
      ll_ff <= ll_in;
      sq_ff <= sq_in;
   end

   assign tol_sq = sq_ff;

endmodule

@@ rtl/pit3_out.sv @@
// Final decision (tolerance compare, third weight, sign tests) feeding the
// output register and a skid register. Depends on pit3_pkg and the macro header.
`include "point_in_triangle_3d_top_macros.svh"
module pit3_out #(
   parameter int COORD_BITS = pit3_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [4*COORD_BITS+7:0]    norm_sq,
   input  logic signed [4*COORD_BITS+7:0]    weight_b,
   input  logic signed [4*COORD_BITS+7:0]    weight_c,
   input  logic [2*pit3_pkg::TOL_BITS-1:0]   tol_sq,
   output logic                              en,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pit3_pkg::verdict_type             verdict
);
   localparam int SW = 4 * COORD_BITS + 8;
   localparam int TQ = 2 * pit3_pkg::TOL_BITS;
   localparam int CW = ((SW > TQ) ? SW : TQ) + 1;
   localparam int AW = SW + 2;

   logic signed [CW-1:0] nn_x, tt_x;
   logic signed [AW-1:0] weight_a;
   logic tri_ok, take_in, out_free;
   pit3_pkg::verdict_type verdict_in;

   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   pit3_pkg::verdict_type out_ff, out_in, skid_ff, skid_in;

   assign nn_x     = CW'(norm_sq);
   assign tt_x     = CW'(tol_sq);
   assign tri_ok   = nn_x > tt_x;
   assign weight_a = AW'(norm_sq) - AW'(weight_b) - AW'(weight_c);

   assign verdict_in.triangle_valid = tri_ok;
   assign verdict_in.point_inside   = tri_ok && !weight_a[AW-1]
                                    && !weight_b[SW-1] && !weight_c[SW-1];

   assign en       = !skid_valid_ff;
   assign take_in  = in_valid && en;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = verdict_in;
            out_valid_in = take_in;
         end
      end else if (take_in) begin
         // output stalled: park the request's result
         skid_in       = verdict_in;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign verdict   = out_ff;

   `PIT3_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid holds a result while the output register is empty")
   `PIT3_ASSERT_IMPL(a_inside_needs_valid, clock, reset, out_valid_ff && out_ff.point_inside,
      out_ff.triangle_valid, "point reported inside an invalid triangle")
   `PIT3_ASSERT_IMPL(a_skid_fill_on_stall, clock, reset, $rose(skid_valid_ff),
      $past(out_valid_ff && !rsp_ready), "skid filled without an output stall")
   `PIT3_ASSERT_NEXT(a_skid_hold, clock, reset, skid_valid_ff && !rsp_ready,
      skid_valid_ff, "skid drained while output stalled")

endmodule

@@ rtl/point_in_triangle_3d_top.sv @@
// Top level of the barycentric point-in-triangle test: stream ports, tolerance
// register, pipeline. Depends on pit3_pkg, pit3_cross, pit3_dot, pit3_tol_sq, pit3_out.
//
//   port group   dir  payload
//   req_*        in   tdata: point xyz, vertex a xyz, b xyz, c xyz (COORD_BITS each)
//   rsp_*        out  tdata: triangle_valid, point_inside, zero fill
//   csr_*        in   normal_tolerance, 42 bits, write only
//
// One request per clock while req_tready is high. Five pipeline stages plus the output
// register; the wide products set the stage split.
// Reset clears all valid bits and sets the tolerance to 1.
// A new tolerance takes effect once it has passed tol_ff and the squaring stages.
// When the output stalls, one more result lands in the skid register; after that
// req_tready drops and the pipeline holds until the skid register drains.
module point_in_triangle_3d_top #(
   parameter int COORD_BITS = pit3_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // point_x, point_y, point_z, vertex_a_x .. vertex_c_z, zero fill
   input  logic [((pit3_pkg::REQ_FIELDS*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // triangle_valid, point_inside, zero fill
   output logic [pit3_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [pit3_pkg::TOL_BITS-1:0]        csr_wr_data
);
   localparam int XW = 2 * COORD_BITS + 3;
   localparam int SW = 4 * COORD_BITS + 8;

   logic signed [COORD_BITS-1:0] point [pit3_pkg::AXES];
   logic signed [COORD_BITS-1:0] vtx_a [pit3_pkg::AXES];
   logic signed [COORD_BITS-1:0] vtx_b [pit3_pkg::AXES];
   logic signed [COORD_BITS-1:0] vtx_c [pit3_pkg::AXES];

   logic [pit3_pkg::TOL_BITS-1:0]   tol_ff;
   logic [2*pit3_pkg::TOL_BITS-1:0] tol_sq;

   logic en, cross_valid, dot_valid;
   logic signed [XW-1:0] normal [pit3_pkg::AXES];
   logic signed [XW-1:0] cross_b [pit3_pkg::AXES];
   logic signed [XW-1:0] cross_c [pit3_pkg::AXES];
   logic signed [SW-1:0] norm_sq, weight_b, weight_c;
   pit3_pkg::verdict_type verdict;

   for (genvar i = 0; i < pit3_pkg::AXES; i++) begin : g_unpack
      assign point[i] = $signed(req_tdata[i*COORD_BITS +: COORD_BITS]);
      assign vtx_a[i] = $signed(req_tdata[(3+i)*COORD_BITS +: COORD_BITS]);
      assign vtx_b[i] = $signed(req_tdata[(6+i)*COORD_BITS +: COORD_BITS]);
      assign vtx_c[i] = $signed(req_tdata[(9+i)*COORD_BITS +: COORD_BITS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= pit3_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   pit3_tol_sq u_tol_sq (
      .clock     (clock),
      .tolerance (tol_ff),
      .tol_sq    (tol_sq)
   );

   pit3_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .point     (point),
      .vertex_a  (vtx_a),
      .vertex_b  (vtx_b),
      .vertex_c  (vtx_c),
      .out_valid (cross_valid),
      .normal    (normal),
      .cross_b   (cross_b),
      .cross_c   (cross_c)
   );

   pit3_dot #(.COORD_BITS(COORD_BITS)) u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cross_valid),
      .normal    (normal),
      .cross_b   (cross_b),
      .cross_c   (cross_c),
      .out_valid (dot_valid),
      .norm_sq   (norm_sq),
      .weight_b  (weight_b),
      .weight_c  (weight_c)
   );

   pit3_out #(.COORD_BITS(COORD_BITS)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .norm_sq   (norm_sq),
      .weight_b  (weight_b),
      .weight_c  (weight_c),
      .tol_sq    (tol_sq),
      .en        (en),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .verdict   (verdict)
   );

   assign req_tready = en;
   assign rsp_tdata  = {{(pit3_pkg::RSP_DATA_BITS - $bits(verdict)){1'b0}}, verdict};

endmodule

@@ verif/point_in_triangle_3d_top_tb.sv @@
// Self-checking bench for point_in_triangle_3d_top: directed table, then random phases under
// several tolerance settings, results compared with the table or an exact integer predictor.
// Depends on pit3_pkg and the RTL under rtl/ only.
`timescale 1ns / 1ps

module point_in_triangle_3d_top_tb;

   localparam int COORD_BITS = pit3_pkg::COORD_BITS_DEFAULT;
   localparam int REQ_FIELDS = pit3_pkg::REQ_FIELDS;
   localparam int AXES = pit3_pkg::AXES;
   localparam int TOL_BITS = pit3_pkg::TOL_BITS;
   localparam int RSP_DATA_BITS = pit3_pkg::RSP_DATA_BITS;
   localparam int REQ_BITS = ((REQ_FIELDS * COORD_BITS + 7) / 8) * 8;
   localparam int IDX_P = 0;
   localparam int IDX_A = 3;
   localparam int IDX_B = 6;
   localparam int IDX_C = 9;
   localparam int MAXC = 524287;
   localparam int MINC = -524288;
   localparam int ALT_HI = 349525;    // 0x55555
   localparam int ALT_LO = -349526;   // 0xAAAAA

   typedef pit3_pkg::verdict_type verdict_type;

   localparam logic [TOL_BITS-1:0] TOL_ZERO = '0;
   localparam logic [TOL_BITS-1:0] TOL_ONE = 1;
   localparam logic [TOL_BITS-1:0] TOL_MAX = '1;
   localparam verdict_type V_INVALID = '0;
   localparam verdict_type V_INSIDE = '1;
   localparam verdict_type V_ANY = '0;
   localparam bit CHECK_FIXED = 1'b1;
   localparam bit CHECK_PRED = 1'b0;
   localparam int PIPE_DEPTH = 6;
   localparam int LONG_HOLD = 80;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 110;
   localparam int DIR_ROWS = 23;

   typedef logic [COORD_BITS-1:0] coord_type;
   // element 0 in the low bits: same layout as req_tdata
   typedef logic [REQ_FIELDS-1:0][COORD_BITS-1:0] tri_req_type;
   typedef logic signed [127:0] wide_type;
   typedef longint vec3_type [AXES];
   typedef enum logic [1:0] {PACE_FREE, PACE_RANDOM, PACE_COMB} pace_mode_type;

   typedef struct {
      logic [TOL_BITS-1:0] tol;
      bit                  known;
      verdict_type         want;
      int                  crd [REQ_FIELDS];
   } dir_row_type;

   // point xyz, vertex a xyz, vertex b xyz, vertex c xyz
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{TOL_ONE, CHECK_FIXED, V_INVALID, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{TOL_ONE, CHECK_FIXED, V_INVALID,
        '{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}},
      '{TOL_ONE, CHECK_FIXED, V_INVALID,
        '{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC}},
      // |n| equal to the tolerance is not enough
      '{TOL_ONE, CHECK_FIXED, V_INVALID, '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0}},
      '{TOL_ONE, CHECK_PRED, V_ANY, '{5, 5, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0}},
      '{TOL_ONE, CHECK_PRED, V_ANY, '{6, 5, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0}},
      '{TOL_ONE, CHECK_PRED, V_ANY, '{3, 3, -7, 0, 0, 0, 10, 0, 0, 0, 10, 0}},
      '{TOL_ONE, CHECK_PRED, V_ANY, '{0, 10, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0}},
      '{TOL_ONE, CHECK_PRED, V_ANY, '{-1, 0, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0}},
      '{TOL_ONE, CHECK_PRED, V_ANY,
        '{0, 0, 0, MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC}},
      '{TOL_ONE, CHECK_PRED, V_ANY,
        '{MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC}},
      '{TOL_ONE, CHECK_PRED, V_ANY,
        '{MINC, MINC, MINC, MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC}},
      '{TOL_ONE, CHECK_PRED, V_ANY,
        '{MAXC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC}},
      '{TOL_ONE, CHECK_PRED, V_ANY,
        '{ALT_HI, ALT_LO, ALT_HI, ALT_LO, ALT_HI, ALT_LO,
          ALT_HI, ALT_HI, ALT_LO, ALT_LO, ALT_LO, ALT_HI}},
      // zero tolerance: degenerate triangles still fail
      '{TOL_ZERO, CHECK_FIXED, V_INVALID, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{TOL_ZERO, CHECK_FIXED, V_INVALID, '{1, 1, 1, 0, 0, 0, 1, 1, 1, 2, 2, 2}},
      '{TOL_ZERO, CHECK_FIXED, V_INVALID, '{7, -3, 2, 7, -3, 2, 7, -3, 2, 100, 50, -9}},
      '{TOL_ZERO, CHECK_FIXED, V_INSIDE, '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0}},
      '{TOL_ZERO, CHECK_PRED, V_ANY, '{1, 1, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0}},
      '{TOL_ZERO, CHECK_PRED, V_ANY, '{0, 0, MAXC, 0, 0, 0, 1, 0, 0, 0, 1, 0}},
      '{TOL_MAX, CHECK_FIXED, V_INVALID, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{TOL_MAX, CHECK_PRED, V_ANY,
        '{0, 0, 0, MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC}},
      '{TOL_MAX, CHECK_PRED, V_ANY,
        '{MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC}}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_wr_en = 1'b0;
   logic [TOL_BITS-1:0]       csr_wr_data = '0;

   logic [TOL_BITS-1:0] tol_model = pit3_pkg::TOL_RESET;
   verdict_type         verdict_q [$];
   int                  fails = 0;
   int                  n_sent = 0;
   int                  n_checked = 0;
   int                  n_valid = 0;
   int                  n_inside = 0;
   int                  n_tol = 0;
   int                  burst_left = 0;
   int                  idle_cycles = 0;
   int                  hold_asks = 0;
   int                  hold_seen = 0;
   int                  hold_left = 0;
   int                  pace_left = 0;
   int                  pace_tick = 0;
   pace_mode_type       pace_mode = PACE_FREE;

   point_in_triangle_3d_top #(.COORD_BITS(COORD_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic longint coord(input tri_req_type r, input int k);
      return longint'(signed'(r[k]));
   endfunction

   function automatic void cross3(input vec3_type u, input vec3_type v, output vec3_type w);
      w[0] = u[1] * v[2] - u[2] * v[1];
      w[1] = u[2] * v[0] - u[0] * v[2];
      w[2] = u[0] * v[1] - u[1] * v[0];
   endfunction

   function automatic wide_type dot3(input vec3_type u, input vec3_type v);
      return wide_type'(u[0]) * wide_type'(v[0]) + wide_type'(u[1]) * wide_type'(v[1])
           + wide_type'(u[2]) * wide_type'(v[2]);
   endfunction

   // Weights sB, sC, sA scaled by |n|^2; no division needed, only signs matter.
   function automatic verdict_type predict_verdict(input tri_req_type r,
                                                   input logic [TOL_BITS-1:0] tol);
      vec3_type e1, e2, d, nrm, t;
      wide_type nn, tt, sb, sc, sa;
      verdict_type v;
      for (int k = 0; k < AXES; k++) begin
         e1[k] = coord(r, IDX_B + k) - coord(r, IDX_A + k);
         e2[k] = coord(r, IDX_C + k) - coord(r, IDX_A + k);
         d[k]  = coord(r, IDX_P + k) - coord(r, IDX_A + k);
      end
      cross3(e1, e2, nrm);
      nn = dot3(nrm, nrm);
      tt = wide_type'(tol) * wide_type'(tol);
      cross3(d, e2, t);
      sb = dot3(nrm, t);
      cross3(e1, d, t);
      sc = dot3(nrm, t);
      sa = nn - sb - sc;
      v.triangle_valid = nn > tt;
      v.point_inside = v.triangle_valid && !sa[127] && !sb[127] && !sc[127];
      return v;
   endfunction

   function automatic int srand(input int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // Mix: full-range noise, triangles with a point steered near them, collinear sets,
   // and tiny coordinates that land on edges and vertices often.
   function automatic tri_req_type random_request();
      tri_req_type r;
      int pick, span, ia, ib, ctr, va, vb, vc, step, km, mm, base;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         for (int k = 0; k < REQ_FIELDS; k++)
            r[k] = coord_type'($urandom);
      end else if (pick < 8) begin
         span = 1 << $urandom_range(1, 16);
         ia = $urandom_range(0, 8);
         ib = $urandom_range(0, 8);
         for (int k = 0; k < AXES; k++) begin
            ctr = srand(131071);
            va = ctr + srand(span);
            vb = ctr + srand(span);
            vc = ctr + srand(span);
            r[IDX_A + k] = coord_type'(va);
            r[IDX_B + k] = coord_type'(vb);
            r[IDX_C + k] = coord_type'(vc);
            r[IDX_P + k] = coord_type'(va + (ia * (vb - va) + ib * (vc - va)) / 8
                                    + (($urandom_range(0, 3) == 0) ? srand(2) : 0));
         end
      end else if (pick == 8) begin
         km = srand(8);
         mm = srand(8);
         for (int k = 0; k < AXES; k++) begin
            step = srand(64);
            base = srand(1 << 18);
            r[IDX_P + k] = coord_type'($urandom);
            r[IDX_A + k] = coord_type'(base);
            r[IDX_B + k] = coord_type'(base + km * step);
            r[IDX_C + k] = coord_type'(base + mm * step);
         end
      end else begin
         for (int k = 0; k < REQ_FIELDS; k++)
            r[k] = coord_type'(srand(4));
      end
      return r;
   endfunction

   task automatic push_req(input tri_req_type r, input verdict_type want);
      req_tvalid <= 1'b1;
      req_tdata <= r;
      do @(posedge clock); while (!req_tready);
      verdict_q.push_back(want);
      n_sent++;
   endtask

   task automatic push_paced(input tri_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push_req(r, predict_verdict(r, tol_model));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   task automatic set_tolerance(input logic [TOL_BITS-1:0] v);
      wait_drained();
      repeat (PIPE_DEPTH + 2) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // let the write pass tol_ff and the squaring stages before the new value is used
      repeat (3) @(posedge clock);
      tol_model = v;
      n_tol++;
   endtask

   // receiver pacing; a hold request from the stimulus forces a long stall
   always @(posedge clock) begin
      pace_tick <= pace_tick + 1;
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (pace_left == 0) begin
            pace_mode <= pace_mode_type'($urandom_range(0, 2));
            pace_left <= $urandom_range(16, 96);
         end else begin
            pace_left <= pace_left - 1;
         end
         case (pace_mode)
            PACE_FREE:   rsp_tready <= 1'b1;
            PACE_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            default:     rsp_tready <= (pace_tick % 7) < 4;
         endcase
      end
   end

   always @(posedge clock) begin : result_check
      verdict_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = verdict_type'(rsp_tdata[1:0]);
         n_valid += int'(got.triangle_valid);
         n_inside += int'(got.point_inside);
         if (verdict_q.size() == 0) begin
            $error("result with no request pending: tdata %h", rsp_tdata);
            fails++;
         end else begin
            want = verdict_q.pop_front();
            n_checked++;
            if (got.triangle_valid !== want.triangle_valid) begin
               $error("triangle_valid: expected %0d, got %0d",
                      want.triangle_valid, got.triangle_valid);
               fails++;
            end
            if (got.point_inside !== want.point_inside) begin
               $error("point_inside: expected %0d, got %0d",
                      want.point_inside, got.point_inside);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("timeout: %0d results outstanding", verdict_q.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      tri_req_type r;
      logic [TOL_BITS-1:0] tol_plan [PHASES];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_tab[i].tol != tol_model)
            set_tolerance(dir_tab[i].tol);
         for (int k = 0; k < REQ_FIELDS; k++)
            r[k] = coord_type'(dir_tab[i].crd[k]);
         if (dir_tab[i].known)
            push_req(r, dir_tab[i].want);
         else
            push_req(r, predict_verdict(r, tol_model));
      end

      tol_plan[0] = TOL_ZERO;
      tol_plan[1] = TOL_BITS'($urandom_range(0, 1 << 24));
      tol_plan[2] = TOL_ONE;
      tol_plan[3] = TOL_MAX;
      tol_plan[4] = TOL_BITS'({$urandom, $urandom});
      tol_plan[5] = TOL_BITS'($urandom) << $urandom_range(0, 10);
      for (int ph = 0; ph < PHASES; ph++) begin
         set_tolerance(tol_plan[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == 30) begin
               // stall the output and keep offering so the pipeline backs up
               hold_asks <= hold_asks + 1;
               for (int j = 0; j < 40; j++) begin
                  r = random_request();
                  push_req(r, predict_verdict(r, tol_model));
               end
            end
            if (ph == 4 && n == 60)
               wait_drained();
            push_paced(random_request());
         end
      end

      wait_drained();
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      $display("%0d requests over %0d tolerance writes, %0d results checked", n_sent, n_tol,
               n_checked);
      $display("%0d triangles valid, %0d points inside, %0d mismatches", n_valid, n_inside,
               fails);
      if (fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pit3_pkg.sv
rtl/pit3_cross.sv
rtl/pit3_dot.sv
rtl/pit3_tol_sq.sv
rtl/pit3_out.sv
rtl/point_in_triangle_3d_top.sv
verif/point_in_triangle_3d_top_tb.sv
